// ===== src/fmp_pkg.sv =====
`default_nettype none
package fmp_pkg;

    // Field and arithmetic widths
    localparam int unsigned ExpBitsDefault = 63;
    localparam int unsigned ExpWidth       = 63;
    localparam int unsigned ValWidth       = 30;
    localparam int unsigned InDataWidth    = 64;
    localparam int unsigned OutDataWidth   = 64;

    // Modulus 1e9+7
    localparam logic [ValWidth-1:0] PrimeMod = 30'd1000000007;

    typedef logic [ValWidth-1:0] val_t;

    // Request to the modular multiplier
    typedef struct packed {
        logic start;
        val_t op_a;
        val_t op_b;
    } mul_req_t;

    // Answer from the modular multiplier
    typedef struct packed {
        logic done;
        val_t prod;
    } mul_rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_MUL,
        ST_WAIT,
        ST_COPY,
        ST_FINISH
    } seq_state_t;

    // (x + y) mod p for x, y below p
    function automatic val_t add_mod(input val_t x, input val_t y);
        logic [ValWidth:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, PrimeMod})
        begin
            s = s - {1'b0, PrimeMod};
        end
        return s[ValWidth-1:0];
    endfunction

    // Pick one of four values
    function automatic val_t sel4(input logic [1:0] idx, input val_t v0, input val_t v1,
                                  input val_t v2, input val_t v3);
        val_t r;
        case (idx)
            2'd0:    r = v0;
            2'd1:    r = v1;
            2'd2:    r = v2;
            default: r = v3;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/fibonacci_matrix_power_mod_core.sv =====
`default_nettype none
// Scans the exponent bits up to and including the first set bit without multiplying, then runs
//   eight modular products per bit (one radix-4 multiplier, 15 digit steps each).
// One item at a time; the next item is taken as soon as the result sits in the output register.
// Reset (rst_n, asynchronous, active low) clears the sequencer and output valid.
module fibonacci_matrix_power_mod_core #(
    parameter int unsigned EXP_BITS = fmp_pkg::ExpBitsDefault
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    input  wire logic [fmp_pkg::InDataWidth-1:0]  s_axis_tdata,  // exponent[62:0], pad
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output      logic [fmp_pkg::OutDataWidth-1:0] m_axis_tdata   // fib_next, fib_this, pad
);
    import fmp_pkg::*;

    localparam int unsigned CntW = $clog2(EXP_BITS + 1);

    seq_state_t          state_reg, state_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic                started_reg, started_next;
    logic [2:0]          idx_reg, idx_next;
    val_t                m0_reg, m1_reg, m2_reg, m3_reg;
    val_t                m0_next, m1_next, m2_next, m3_next;
    val_t                t0_reg, t1_reg, t2_reg, t3_reg;
    val_t                t0_next, t1_next, t2_next, t3_next;
    logic                ov_reg, ov_next;
    val_t                on_reg, on_next, ot_reg, ot_next;

    mul_req_t req;
    mul_rsp_t rsp;
    val_t     tcur, tsum;
    logic     msb;

    fmp_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign msb = exp_reg[EXP_BITS-1];

    // Squaring schedule: entry e = idx[2:1], term j = idx[0]
    assign req.op_a  = sel4({idx_reg[2], idx_reg[0]}, m0_reg, m1_reg, m2_reg, m3_reg);
    assign req.op_b  = sel4({idx_reg[0], idx_reg[1]}, m0_reg, m1_reg, m2_reg, m3_reg);
    assign req.start = (state_reg == ST_MUL);
    assign tcur      = sel4(idx_reg[2:1], t0_reg, t1_reg, t2_reg, t3_reg);
    assign tsum      = idx_reg[0] ? add_mod(tcur, rsp.prod) : rsp.prod;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        exp_next     = exp_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        idx_next     = idx_reg;
        {m0_next, m1_next, m2_next, m3_next} = {m0_reg, m1_reg, m2_reg, m3_reg};
        {t0_next, t1_next, t2_next, t3_next} = {t0_reg, t1_reg, t2_reg, t3_reg};
        ov_next = ov_reg;
        on_next = on_reg;
        ot_next = ot_reg;
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    exp_next     = s_axis_tdata[EXP_BITS-1:0];
                    cnt_next     = CntW'(EXP_BITS);
                    started_next = 1'b0;
                    m0_next = val_t'(1);
                    m1_next = '0;
                    m2_next = '0;
                    m3_next = val_t'(1);
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (!started_reg)
                begin
                    // identity squared is identity; first set bit loads the base
                    if (msb)
                    begin
                        started_next = 1'b1;
                        m0_next = val_t'(1);
                        m1_next = val_t'(1);
                        m2_next = val_t'(1);
                        m3_next = '0;
                    end
                    exp_next = {exp_reg[EXP_BITS-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    case (idx_reg[2:1])
                        2'd0:    t0_next = tsum;
                        2'd1:    t1_next = tsum;
                        2'd2:    t2_next = tsum;
                        default: t3_next = tsum;
                    endcase
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg == 3'd7) ? ST_COPY : ST_MUL;
                end
            end
            ST_COPY:
            begin
                // on a set bit, product times base: [a+b, a; c+d, c]; else the product is copied
                if (msb)
                begin
                    m0_next = add_mod(t0_reg, t1_reg);
                    m1_next = t0_reg;
                    m2_next = add_mod(t2_reg, t3_reg);
                    m3_next = t2_reg;
                end
                else
                begin
                    {m0_next, m1_next, m2_next, m3_next} = {t0_reg, t1_reg, t2_reg, t3_reg};
                end
                exp_next   = {exp_reg[EXP_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_BIT;
            end
            ST_FINISH:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    on_next    = m0_reg;
                    ot_next    = m1_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            idx_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
            idx_reg     <= idx_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        m0_reg  <= m0_next;
        m1_reg  <= m1_next;
        m2_reg  <= m2_next;
        m3_reg  <= m3_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        t3_reg  <= t3_next;
        on_reg  <= on_next;
        ot_reg  <= ot_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {{(OutDataWidth - 2 * ValWidth){1'b0}}, ot_reg, on_reg};

endmodule
`default_nettype wire

// ===== src/fmp_mulmod.sv =====
`default_nettype none
// Radix-4 interleaved modular multiplier: two bits of op_a per cycle.
module fmp_mulmod (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fmp_pkg::mul_req_t req,
    output fmp_pkg::mul_rsp_t     rsp
);
    import fmp_pkg::*;

    localparam int unsigned Digits = ValWidth / 2;
    localparam int unsigned CntW   = $clog2(Digits + 1);
    localparam int unsigned TW     = ValWidth + 3;

    val_t            r_reg, r_next;
    val_t            a_reg, a_next;
    val_t            b_reg, b_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [1:0]    dig;
    logic [TW-1:0] acc;
    logic [TW-1:0] rem;
    logic [TW-1:0] pw;

    // One digit step: acc = 4r + d*b, then subtract the largest multiple of p
    always_comb
    begin
        dig = a_reg[ValWidth-1 -: 2];
        pw  = {3'b000, PrimeMod};
        acc = {1'b0, r_reg, 2'b00};
        if (dig[0])
        begin
            acc = acc + {3'b000, b_reg};
        end
        if (dig[1])
        begin
            acc = acc + {2'b00, b_reg, 1'b0};
        end
        if (acc >= TW'(6) * pw)
            rem = acc - TW'(6) * pw;
        else if (acc >= TW'(5) * pw)
            rem = acc - TW'(5) * pw;
        else if (acc >= TW'(4) * pw)
            rem = acc - TW'(4) * pw;
        else if (acc >= TW'(3) * pw)
            rem = acc - TW'(3) * pw;
        else if (acc >= TW'(2) * pw)
            rem = acc - TW'(2) * pw;
        else if (acc >= pw)
            rem = acc - pw;
        else
            rem = acc;
    end

    // Step control
    always_comb
    begin
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            r_next    = '0;
            a_next    = req.op_a;
            b_next    = req.op_b;
            cnt_next  = CntW'(Digits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = rem[ValWidth-1:0];
            a_next   = {a_reg[ValWidth-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = r_reg;

endmodule
`default_nettype wire

// ===== src/fmp_checker.sv =====
`default_nettype none
module fmp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);
    import fmp_pkg::*;

    // An accepted item closes the input in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // Results are fully reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[29:0] < PrimeMod && m_axis_tdata[59:30] < PrimeMod))
        else $error("result not reduced");

    // A stalled result stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // F(k) and F(k+1) never both zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[59:0] != 60'd0))
        else $error("zero result row");

endmodule

bind fibonacci_matrix_power_mod_core fmp_checker u_fmp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== dv/fib_power_checker.sv =====
`timescale 1ns / 1ps
module fib_power_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    output int               fail_count,
    output int               pending
);
    import fmp_pkg::*;

    typedef struct packed {
        val_t fib_next;
        val_t fib_this;
    } fib_pair_t;

    fib_pair_t fib_queue[$];

    // a * b mod p
    function automatic val_t mulmod(input val_t a, input val_t b);
        logic [63:0] p;
        p = {34'd0, a} * {34'd0, b};
        return val_t'(p % 64'd1000000007);
    endfunction

    function automatic val_t addmod(input val_t a, input val_t b);
        logic [31:0] s;
        s = {2'b0, a} + {2'b0, b};
        if (s >= 32'd1000000007)
        begin
            s = s - 32'd1000000007;
        end
        return val_t'(s);
    endfunction

    // B^k top row, scanning exponent bits from the top down
    function automatic fib_pair_t fib_power(input logic [62:0] k);
        val_t m0, m1, m2, m3, t0, t1, t2, t3;
        m0 = 1; m1 = 0; m2 = 0; m3 = 1;
        for (int i = 62; i >= 0; i--)
        begin
            t0 = addmod(mulmod(m0, m0), mulmod(m1, m2));
            t1 = addmod(mulmod(m0, m1), mulmod(m1, m3));
            t2 = addmod(mulmod(m2, m0), mulmod(m3, m2));
            t3 = addmod(mulmod(m2, m1), mulmod(m3, m3));
            m0 = t0; m1 = t1; m2 = t2; m3 = t3;
            if (k[i])
            begin
                // times [[1,1],[1,0]]
                t0 = addmod(m0, m1);
                t2 = addmod(m2, m3);
                m1 = m0; m3 = m2;
                m0 = t0; m2 = t2;
            end
        end
        return '{fib_next: m0, fib_this: m1};
    endfunction

    assign pending = fib_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        fib_pair_t want;
        fib_pair_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                fib_queue.push_back(fib_power(s_axis_tdata[62:0]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.fib_next = m_axis_tdata[29:0];
                got.fib_this = m_axis_tdata[59:30];
                if (fib_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result next=%0d this=%0d",
                                 got.fib_next, got.fib_this);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = fib_queue.pop_front();
                    if (want != got)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp next=%0d this=%0d, got next=%0d this=%0d",
                                     want.fib_next, want.fib_this,
                                     got.fib_next, got.fib_this);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    int          fail_count;
    int          pending;

    fibonacci_matrix_power_mod_core dut (.*);

    fib_power_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // receiver stalls: ready is random, high with a probability of about 70 percent
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) < 60);
        end
    end

    // exponent: mostly small, some full width, some with junk in bit 63
    function automatic logic [63:0] pick_exponent();
        logic [63:0] e;
        e = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: e = e & 64'hFF;
            3, 4:    e = e & 64'hFFFF_FFFF;
            5:       e = e & ((64'd1 << $urandom_range(1, 62)) - 1);
            default: ;
        endcase
        return e;
    endfunction

    task automatic send_exponent(input logic [63:0] e);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= e;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
            s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] directed [$];
        int burst;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // zero, small, powers of two, all ones, bit 63 ignored
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd10, 64'd44, 64'd45, 64'd90,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                     64'h4000_0000_0000_0000, 64'h5555_5555_5555_5555,
                     64'h2AAA_AAAA_AAAA_AAAA, 64'd1000000006, 64'd2000000016};
        foreach (directed[i])
        begin
            send_exponent(directed[i]);
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 5));
        end

        // hold off until the block has drained
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);

        for (int n = 0; n < 580; )
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 580; b++, n++)
                send_exponent(pick_exponent());
            idle_gap($urandom_range(0, 20));
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("[fibonacci_matrix_power_mod_core] OK");
        else
            $display("[fibonacci_matrix_power_mod_core] ERROR");
        $finish;
    end

    // watchdog for the whole run, allowing for worst-case items and receiver stalls
    initial
    begin
        #400ms;
        $display("[fibonacci_matrix_power_mod_core] ERROR");
        $finish;
    end
endmodule
